// ===== rtl/pcm_voice_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// PCM voice mixer assertion macros
// Clocked assertion forms shared by the checker of the voice mixer.
// ----------------------------------------------------------------------------
`ifndef PCM_VOICE_MIXER_MACROS_SVH
`define PCM_VOICE_MIXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcm_voice_mixer check failed");

// The consequent must hold in the cycle after the antecedent.
`define PVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcm_voice_mixer check failed");

`endif

// ===== rtl/pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer package
// Widths, register indexes, queue entry and configuration types shared by
// the front end, the queue and the mixing back end.
// ----------------------------------------------------------------------------
package pvm_pkg;

  localparam int POS_W      = 17;
  localparam int ACC_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int ADDR_IN_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int SUM_W      = ACC_W + 2;
  localparam int PROD_W     = 33;
  localparam int SCALED_W   = PROD_W - 15;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);

  localparam int FMT_WIDE_BIT   = 0;
  localparam int FMT_STEREO_BIT = 1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MIX  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_FORMAT = 3'd0,
    CFG_LOOP_ENABLE   = 3'd1,
    CFG_CLIP_LENGTH   = 3'd2,
    CFG_LEFT_GAIN     = 3'd3,
    CFG_RIGHT_GAIN    = 3'd4,
    CFG_STEREO_OUTPUT = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PASS = 2'd1,
    OP_MIX  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]        sample_format;
    logic              loop_enable;
    logic [POS_W-1:0]  clip_length;
    logic [GAIN_W-1:0] left_gain;
    logic [GAIN_W-1:0] right_gain;
    logic              stereo_output;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic [ADDR_IN_W-1:0]    load_address;
    logic [7:0]              load_byte;
    logic [POS_W-1:0]        pos_lo;
    logic [POS_W-1:0]        pos_hi;
    logic                    is_wide;
    logic                    sample_zero;
    logic signed [ACC_W-1:0] left_in;
    logic signed [ACC_W-1:0] right_in;
    logic                    finished;
  } entry_t;

  function automatic logic [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic [ACC_W-1:0] r;
    if (v[SUM_W-1:ACC_W-1] == '0 || v[SUM_W-1:ACC_W-1] == '1) begin
      r = v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/pvm_front.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer front end
// Keeps the read position and the done flag, classifies each input beat
// as a load, a pass-through or a mix, and builds its queue entry for the back end.
// ----------------------------------------------------------------------------
module pvm_front #(
  parameter int CLIP_BYTES = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pvm_pkg::cfg_t                   cfg,
  input  logic                            push,
  input  logic                            kind,
  input  logic [pvm_pkg::ADDR_IN_W-1:0]   load_address,
  input  logic [7:0]                      load_byte,
  input  logic signed [pvm_pkg::ACC_W-1:0] mix_left_in,
  input  logic signed [pvm_pkg::ACC_W-1:0] mix_right_in,
  output pvm_pkg::entry_t                 entry
);
  import pvm_pkg::*;

  localparam int CAP_INT = (CLIP_BYTES < (2 ** POS_W)) ? CLIP_BYTES : (2 ** POS_W) - 1;
  localparam logic [POS_W-1:0] LEN_CAP = POS_W'(CAP_INT);

  logic [POS_W-1:0] pos, pos_next;
  logic             done, done_next;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] pos_start;
  logic             done_start;
  logic [2:0]       frame_bytes;
  logic [POS_W:0]   pos_adv;
  logic [POS_W:0]   pos_plus1;
  logic             sample_ok;

  always_comb begin
    len = (cfg.clip_length < LEN_CAP) ? cfg.clip_length : LEN_CAP;
    pos_start  = pos;
    done_start = done;
    if (!done && pos >= len) begin
      if (cfg.loop_enable && len != '0) begin
        pos_start = '0;
      end else if (!cfg.loop_enable) begin
        done_start = 1'b1;
      end
    end
    frame_bytes = cfg.sample_format[FMT_WIDE_BIT] ? 3'd2 : 3'd1;
    if (cfg.sample_format[FMT_STEREO_BIT]) begin
      frame_bytes = frame_bytes << 1;
    end
    pos_adv   = {1'b0, pos_start} + (POS_W + 1)'(frame_bytes);
    pos_plus1 = {1'b0, pos_start} + 1'b1;
    sample_ok = pos_plus1 < {1'b0, len};

    entry.load_address = load_address;
    entry.load_byte    = load_byte;
    entry.pos_lo       = pos_start;
    entry.pos_hi       = sample_ok ? pos_plus1[POS_W-1:0] : pos_start;
    entry.is_wide      = cfg.sample_format[FMT_WIDE_BIT];
    entry.sample_zero  = !sample_ok;
    entry.left_in      = mix_left_in;
    entry.right_in     = mix_right_in;
    entry.finished     = done_start;

    if (kind == KIND_LOAD) begin
      entry.op  = OP_LOAD;
      pos_next  = '0;
      done_next = 1'b0;
    end else if (done_start || pos_start >= len) begin
      entry.op  = OP_PASS;
      pos_next  = pos_start;
      done_next = done_start;
    end else begin
      entry.op  = OP_MIX;
      pos_next  = pos_adv[POS_W-1:0];
      done_next = done_start;
      if (pos_adv >= {1'b0, len}) begin
        pos_next = len;
        if (!cfg.loop_enable) begin
          done_next = 1'b1;
        end
      end
      entry.finished = done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      done <= 1'b0;
    end else if (push) begin
      pos  <= pos_next;
      done <= done_next;
    end
  end

endmodule

// ===== rtl/pvm_queue.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer queue
// Short first-in first-out buffer of classified beats between the front
// end and the back end.
// ----------------------------------------------------------------------------
module pvm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pvm_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output pvm_pkg::entry_t pop_entry
);
  import pvm_pkg::*;

  entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full      = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pvm_back.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer back end
// Holds the clip store, writes load beats into it, and runs mix and pass-through
// beats through a read stage, a gain multiply stage and a saturating sum stage.
// ----------------------------------------------------------------------------
module pvm_back #(
  parameter int CLIP_BYTES = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pvm_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  pvm_pkg::entry_t              q_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pvm_pkg::ACC_W-1:0]    left_out,
  output logic [pvm_pkg::ACC_W-1:0]    right_out,
  output logic                         finished_out
);
  import pvm_pkg::*;

  localparam int ADDR_W = $clog2(CLIP_BYTES);

  logic [7:0] clip_mem [CLIP_BYTES];

  logic                    en_r, en_m, en_a;
  logic                    write_ok;

  logic                    r_valid;
  logic                    r_mix, r_wide, r_zero, r_fin;
  logic [7:0]              rd_lo, rd_hi;
  logic signed [ACC_W-1:0] r_left, r_right;

  logic                    m_valid;
  logic                    m_fin;
  logic signed [PROD_W-1:0] m_prod_l, m_prod_r;
  logic signed [ACC_W-1:0] m_left, m_right;

  logic signed [15:0]       sample;
  logic signed [GAIN_W:0]   gain_l, gain_r;
  logic signed [PROD_W-1:0] rnd_l, rnd_r;
  logic signed [SCALED_W-1:0] scaled_l, scaled_r;
  logic signed [SUM_W-1:0]  sum_l, sum_r;

  assign en_a = !out_valid || out_ready;
  assign en_m = !m_valid || en_a;
  assign en_r = !r_valid || en_m;
  assign pop  = q_valid && en_r;
  assign write_ok = (32'(q_entry.load_address) < 32'(CLIP_BYTES));

  always_ff @(posedge clk) begin
    if (pop && q_entry.op == OP_LOAD && write_ok) begin
      clip_mem[ADDR_W'(q_entry.load_address)] <= q_entry.load_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.op == OP_MIX) begin
      rd_lo <= clip_mem[ADDR_W'(q_entry.pos_lo)];
      rd_hi <= clip_mem[ADDR_W'(q_entry.pos_hi)];
    end
  end

  always_ff @(posedge clk) begin
    if (en_r) begin
      r_mix   <= (q_entry.op == OP_MIX);
      r_wide  <= q_entry.is_wide;
      r_zero  <= q_entry.sample_zero;
      r_fin   <= q_entry.finished;
      r_left  <= q_entry.left_in;
      r_right <= q_entry.right_in;
    end
  end

  always_comb begin
    if (!r_mix) begin
      sample = '0;
    end else if (r_wide) begin
      sample = r_zero ? '0 : $signed({rd_hi, rd_lo});
    end else begin
      sample = $signed({~rd_lo[7], rd_lo[6:0], 8'h00});
    end
    gain_l = r_mix ? $signed({1'b0, cfg.left_gain}) : '0;
    gain_r = (r_mix && cfg.stereo_output) ? $signed({1'b0, cfg.right_gain}) : '0;
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      m_prod_l <= PROD_W'(sample) * PROD_W'(gain_l);
      m_prod_r <= PROD_W'(sample) * PROD_W'(gain_r);
      m_left   <= r_left;
      m_right  <= r_right;
      m_fin    <= r_fin;
    end
  end

  always_comb begin
    rnd_l    = m_prod_l + $signed(ROUND_HALF);
    rnd_r    = m_prod_r + $signed(ROUND_HALF);
    scaled_l = rnd_l[PROD_W-1:15];
    scaled_r = rnd_r[PROD_W-1:15];
    sum_l = {{(SUM_W-ACC_W){m_left[ACC_W-1]}}, m_left}
          + {{(SUM_W-SCALED_W){scaled_l[SCALED_W-1]}}, scaled_l};
    sum_r = {{(SUM_W-ACC_W){m_right[ACC_W-1]}}, m_right}
          + {{(SUM_W-SCALED_W){scaled_r[SCALED_W-1]}}, scaled_r};
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      left_out     <= sat_acc(sum_l);
      right_out    <= sat_acc(sum_r);
      finished_out <= m_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_r) begin
        r_valid <= pop && (q_entry.op == OP_MIX || q_entry.op == OP_PASS);
      end
      if (en_m) begin
        m_valid <= r_valid;
      end
      if (en_a) begin
        out_valid <= m_valid;
      end
    end
  end

endmodule

// ===== rtl/pcm_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer
// One playback voice mixed into a pair of 24-bit accumulators.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while the queue is not full and,
// with the output side ready, returns one output beat per clock for every
// mix beat; load beats return nothing. An accepted mix beat is written into
// the queue, then passes through a clip store read, a gain multiply and a
// saturating sum into the output register, each stage registered. The
// sustained rate of one beat per clock is set by the read position update
// in the front end and the one-entry-per-clock pipeline behind the clip
// store's read port.
// The clip store needs no clearing after reset; reading a byte never loaded
// gives an undefined sample.
module pcm_voice_mixer #(
  parameter int CLIP_BYTES = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // load_address[15:0], load_byte[23:16], mix_left_in[47:24], mix_right_in[71:48]
  input  logic [71:0]                      s_tdata,
  // kind
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // mix_left_out[23:0], mix_right_out[47:24]
  output logic [47:0]                      m_tdata,
  // finished
  output logic                             m_tuser,
  input  logic                             cfg_wr_en,
  input  logic [pvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pvm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pvm_pkg::*;

  logic [1:0]        sample_format;
  logic              loop_enable;
  logic [POS_W-1:0]  clip_length;
  logic [GAIN_W-1:0] left_gain;
  logic [GAIN_W-1:0] right_gain;
  logic              stereo_output;
  cfg_t              cfg;

  logic   q_full, q_not_empty, push, pop;
  entry_t push_entry, pop_entry;
  logic [ACC_W-1:0] left_out, right_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= '0;
      loop_enable   <= 1'b0;
      clip_length   <= '0;
      left_gain     <= GAIN_W'(32768);
      right_gain    <= GAIN_W'(32768);
      stereo_output <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SAMPLE_FORMAT: sample_format <= cfg_wdata[1:0];
        CFG_LOOP_ENABLE:   loop_enable   <= cfg_wdata[0];
        CFG_CLIP_LENGTH:   clip_length   <= cfg_wdata[POS_W-1:0];
        CFG_LEFT_GAIN:     left_gain     <= cfg_wdata[GAIN_W-1:0];
        CFG_RIGHT_GAIN:    right_gain    <= cfg_wdata[GAIN_W-1:0];
        CFG_STEREO_OUTPUT: stereo_output <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.sample_format = sample_format;
    cfg.loop_enable   = loop_enable;
    cfg.clip_length   = clip_length;
    cfg.left_gain     = left_gain;
    cfg.right_gain    = right_gain;
    cfg.stereo_output = stereo_output;
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  pvm_front #(
    .CLIP_BYTES(CLIP_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .kind         (s_tuser),
    .load_address (s_tdata[15:0]),
    .load_byte    (s_tdata[23:16]),
    .mix_left_in  ($signed(s_tdata[47:24])),
    .mix_right_in ($signed(s_tdata[71:48])),
    .entry        (push_entry)
  );

  pvm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  pvm_back #(
    .CLIP_BYTES(CLIP_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_not_empty),
    .q_entry      (pop_entry),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .left_out     (left_out),
    .right_out    (right_out),
    .finished_out (m_tuser)
  );

  assign m_tdata = {right_out, left_out};

endmodule

// ===== rtl/pvm_checker.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer checker
// Port-level checks on reset behavior and the output beat handshake.
// ----------------------------------------------------------------------------
`include "pcm_voice_mixer_macros.svh"

module pvm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  `PVM_ASSERT_SAME(a_no_beat_after_reset, $past(rst), !m_tvalid)
  `PVM_ASSERT_SAME(a_ready_after_reset, $past(rst), s_tready)
  `PVM_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid)
  `PVM_ASSERT_NEXT(a_out_beat_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

endmodule

bind pcm_voice_mixer pvm_checker u_pvm_checker (.*);
